[sv/cse_pkg.sv]
// Shared types and constants for the CAN signal extract and scale block.
// Used by cse_front, cse_div_cell and can_signal_extract_scale_top.
package cse_pkg;

    localparam int VALUE_W   = 16;
    localparam int CODE_W    = 16;
    localparam int DIV_W     = 32;
    localparam int NUM_CELLS = DIV_W;
    localparam int PAYLOAD_W = 64;
    localparam int SHIFT_W   = 6;
    localparam int LEN_W     = 7;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int OUT_TDATA_W = 32;

    localparam logic [15:0] DAC_FULL_SCALE = 16'd4095;

    // Register indexes on the config channel
    localparam logic [CFG_IDX_W-1:0] CFG_BIG_ENDIAN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_BIT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_MIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_MAX  = 3'd4;

    localparam logic [LEN_W-1:0]   RST_LENGTH    = 7'd16;
    localparam logic [VALUE_W-1:0] RST_SCALE_MIN = 16'h0000;
    localparam logic [VALUE_W-1:0] RST_SCALE_MAX = 16'hFFFF;

    // One slot of the divider chain: remainder plus a combined
    // numerator/quotient shift word (numerator bits leave at the top,
    // quotient bits enter at the bottom).
    typedef struct packed {
        logic               valid;
        logic               err;
        logic [VALUE_W-1:0] value;
        logic [DIV_W-1:0]   rem;
        logic [DIV_W-1:0]   nq;
    } cse_cell_t;

    function automatic logic [7:0] swap_nibbles(input logic [7:0] b);
        return {b[3:0], b[7:4]};
    endfunction

endpackage

[sv/can_signal_extract_scale_top.sv]
// Top level of the CAN signal extractor and DAC scaler.
// Instantiates cse_front and a chain of cse_div_cell; depends on cse_pkg.
//
// Each beat on s_tdata is one 8-byte CAN payload (byte 0 in bits 7:0). The
// block pulls one signal out of it, Intel or Motorola order per
// big_endian_mode, masks it to signal_length bits (16-bit result), and maps it
// onto a DAC code (value - scale_min) * 4095 / (scale_max - scale_min), with
// the subtractions and product taken modulo 2^32 and the quotient cut to 16
// bits. Equal bounds give range_error = 1 on m_tuser and a code of 0. The
// block takes one payload beat per clock and returns one result beat per
// payload, in order. The pipeline has two front stages (extract and mask,
// then the numerator product), 32 restoring-division cells that each settle
// one quotient bit, and the output register. Throughput is one beat per
// cycle while the output is not stalled. When m_tready is low with a
// result waiting, the whole pipeline holds and s_tready drops. Write the
// configuration only while no results are outstanding; cfg_ready is always
// high and writes to indexes beyond scale_max are dropped.
module can_signal_extract_scale_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    // slave side: tdata = payload[63:0]
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [cse_pkg::PAYLOAD_W-1:0]     s_tdata,
    // master side: tdata = signal_value[15:0], dac_code[31:16]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [cse_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // master side: tuser = range_error[0]
    output logic                              m_tuser,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cse_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cse_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import cse_pkg::*;

    logic                 big_endian_reg;
    logic [SHIFT_W-1:0]   first_bit_reg;
    logic [LEN_W-1:0]     length_reg;
    logic [VALUE_W-1:0]   scale_min_reg;
    logic [VALUE_W-1:0]   scale_max_reg;
    logic [DIV_W-1:0]     span_reg;
    logic                 advance;
    logic                 out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic [OUT_TDATA_W-1:0] out_data_next;
    logic                 out_err_reg;
    logic [CODE_W-1:0]    code;
    cse_cell_t            chain [NUM_CELLS+1];

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            big_endian_reg <= 1'b0;
            first_bit_reg  <= '0;
            length_reg     <= RST_LENGTH;
            scale_min_reg  <= RST_SCALE_MIN;
            scale_max_reg  <= RST_SCALE_MAX;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_BIG_ENDIAN: big_endian_reg <= cfg_data[0];
                CFG_FIRST_BIT:  first_bit_reg  <= cfg_data[SHIFT_W-1:0];
                CFG_LENGTH:     length_reg     <= cfg_data[LEN_W-1:0];
                CFG_SCALE_MIN:  scale_min_reg  <= cfg_data;
                CFG_SCALE_MAX:  scale_max_reg  <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Divisor wraps modulo 2^32 when max is below min; registered once here
    // and shared by every cell. It settles long before a beat reaches a cell.
    always_ff @(posedge clk)
    begin
        span_reg <= {{(DIV_W-VALUE_W){1'b0}}, scale_max_reg}
                  - {{(DIV_W-VALUE_W){1'b0}}, scale_min_reg};
    end

    // Advance everything whenever the output slot is free or being taken
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = advance;

    cse_front u_front
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .advance          (advance),
        .in_valid         (s_tvalid),
        .payload          (s_tdata),
        .big_endian_mode  (big_endian_reg),
        .first_bit        (first_bit_reg),
        .signal_length    (length_reg),
        .scale_min        (scale_min_reg),
        .span             (span_reg),
        .cell_out         (chain[0])
    );

    // Divider chain: one quotient bit per cell, MSB first
    for (genvar g = 0; g < NUM_CELLS; g++)
    begin : g_cell
        cse_div_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .span     (span_reg),
            .cell_in  (chain[g]),
            .cell_out (chain[g+1])
        );
    end

    // Force the code to zero on an empty range
    assign code = chain[NUM_CELLS].err ? '0 : chain[NUM_CELLS].nq[CODE_W-1:0];
    assign out_data_next = {code, chain[NUM_CELLS].value};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= chain[NUM_CELLS].valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= out_data_next;
            out_err_reg  <= chain[NUM_CELLS].err;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_err_reg;

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[VALUE_W +: CODE_W] == '0)
        else $error("range error with nonzero DAC code");
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output slot");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(out_data_reg) && $stable(out_err_reg))
        else $error("waiting result changed before it was taken");

endmodule

[sv/cse_front.sv]
// Front end: signal extraction, length mask and numerator product.
// Two register stages feeding the divider chain; depends on cse_pkg.
module cse_front
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         advance,
    input  logic                         in_valid,
    input  logic [cse_pkg::PAYLOAD_W-1:0] payload,
    input  logic                         big_endian_mode,
    input  logic [cse_pkg::SHIFT_W-1:0]   first_bit,
    input  logic [cse_pkg::LEN_W-1:0]     signal_length,
    input  logic [cse_pkg::VALUE_W-1:0]   scale_min,
    input  logic [cse_pkg::DIV_W-1:0]     span,
    output cse_pkg::cse_cell_t            cell_out
);
    import cse_pkg::*;

    logic [PAYLOAD_W-1:0] swapped;
    logic [PAYLOAD_W-1:0] shift_src;
    logic [PAYLOAD_W-1:0] shifted;
    logic [SHIFT_W-1:0]   shift_amt;
    logic [VALUE_W-1:0]   raw;
    logic [VALUE_W-1:0]   mask;
    logic [VALUE_W-1:0]   value_next;
    logic                 a_valid_reg;
    logic [VALUE_W-1:0]   a_value_reg;
    logic [VALUE_W:0]     diff;
    logic [DIV_W-1:0]     diff_ext;
    logic [DIV_W-1:0]     num_next;
    logic                 b_valid_reg;
    logic                 b_err_reg;
    logic [VALUE_W-1:0]   b_value_reg;
    logic [DIV_W-1:0]     b_num_reg;

    // Motorola order: byte i lands in byte slot 7-i, nibbles swapped
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            swapped[(7-i)*8 +: 8] = swap_nibbles(payload[i*8 +: 8]);
        end
    end

    always_comb
    begin
        if (big_endian_mode)
        begin
            shift_src = swapped;
            shift_amt = {3'd7 - first_bit[5:3], first_bit[2:0]};
        end
        else
        begin
            shift_src = payload;
            shift_amt = first_bit;
        end
        shifted = shift_src >> shift_amt;
        if (big_endian_mode)
            raw = {shifted[11:8], shifted[15:12], shifted[3:0], shifted[7:4]};
        else
            raw = shifted[VALUE_W-1:0];
        for (int k = 0; k < VALUE_W; k++)
        begin
            mask[k] = (signal_length > LEN_W'(k));
        end
        value_next = raw & mask;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    // (value - min) wraps modulo 2^32: sign-extend the 17-bit difference
    assign diff     = {1'b0, a_value_reg} - {1'b0, scale_min};
    assign diff_ext = {{(DIV_W-VALUE_W-1){diff[VALUE_W]}}, diff};
    assign num_next = diff_ext * {{(DIV_W-16){1'b0}}, DAC_FULL_SCALE};

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_value_reg <= value_next;
            b_value_reg <= a_value_reg;
            b_num_reg   <= num_next;
            b_err_reg   <= (span == '0);
        end
    end

    always_comb
    begin
        cell_out.valid = b_valid_reg;
        cell_out.err   = b_err_reg;
        cell_out.value = b_value_reg;
        cell_out.rem   = '0;
        cell_out.nq    = b_num_reg;
    end

    a_hold_a: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(a_value_reg) && $stable(a_valid_reg))
        else $error("front stage A moved while stalled");
    a_hold_b: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(b_num_reg) && $stable(b_valid_reg))
        else $error("front stage B moved while stalled");

endmodule

[sv/cse_div_cell.sv]
// One restoring-division cell: produces one quotient bit per beat.
// Chained NUM_CELLS deep in the top level; depends on cse_pkg.
module cse_div_cell
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     advance,
    input  logic [cse_pkg::DIV_W-1:0] span,
    input  cse_pkg::cse_cell_t        cell_in,
    output cse_pkg::cse_cell_t        cell_out
);
    import cse_pkg::*;

    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;
    logic             q_bit;
    logic [DIV_W-1:0] rem_next;
    logic             valid_reg;
    logic             err_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] nq_reg;

    // Bring down the next numerator bit, subtract if it fits
    always_comb
    begin
        trial = {cell_in.rem, cell_in.nq[DIV_W-1]};
        diff  = trial - {1'b0, span};
        q_bit = (trial >= {1'b0, span});
        if (q_bit)
            rem_next = diff[DIV_W-1:0];
        else
            rem_next = trial[DIV_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= cell_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            err_reg   <= cell_in.err;
            value_reg <= cell_in.value;
            rem_reg   <= rem_next;
            nq_reg    <= {cell_in.nq[DIV_W-2:0], q_bit};
        end
    end

    always_comb
    begin
        cell_out.valid = valid_reg;
        cell_out.err   = err_reg;
        cell_out.value = value_reg;
        cell_out.rem   = rem_reg;
        cell_out.nq    = nq_reg;
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(nq_reg) && $stable(rem_reg) && $stable(valid_reg))
        else $error("divider cell moved while stalled");
    a_pass_valid: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> valid_reg == $past(cell_in.valid))
        else $error("divider cell lost or invented a beat");

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// Self-checking bench for can_signal_extract_scale_top: a directed table, then randomized
// payload phases under changing register settings, checked against a local predictor.
// Depends on cse_pkg and the RTL of the block only.

module testbench;
    import cse_pkg::*;

    // Two front stages, 32 divider cells and the output register
    localparam int PIPE_LATENCY   = 35;
    // Longest correct quiet stretch is the long sink hold plus one pipeline drain
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_BEATS   = 1000;
    localparam int SINK_HOLD      = 150;
    localparam int REPORT_CAP     = 30;
    localparam int N_DIRECTED     = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_UNUSED = CFG_SCALE_MAX + 3'd3;

    // Value and code sit in m_tdata from bit 0 up; the error flag rides on m_tuser
    typedef struct packed {
        logic               err;
        logic [CODE_W-1:0]  code;
        logic [VALUE_W-1:0] value;
    } reading_t;

    typedef struct packed {
        logic               big_endian;
        logic [SHIFT_W-1:0] first_bit;
        logic [LEN_W-1:0]   length;
        logic [VALUE_W-1:0] scale_min;
        logic [VALUE_W-1:0] scale_max;
    } scaler_cfg_t;

    // typed = 1: the expected reading is written into the row by hand
    typedef struct packed {
        scaler_cfg_t            cfg;
        logic [PAYLOAD_W-1:0]   payload;
        logic                   typed;
        reading_t               want;
    } directed_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [PAYLOAD_W-1:0]   s_tdata;      // payload[63:0]
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;      // signal_value[15:0], dac_code[31:16]
    logic                   m_tuser;      // range_error[0]
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Local copy of the block's register file, updated as each write beat lands
    scaler_cfg_t   live_cfg;
    reading_t      pending_readings[$];
    directed_row_t directed_rows[N_DIRECTED];

    logic hold_sink;
    int   mismatch_count;
    int   beats_sent;
    int   readings_checked;
    int   random_beats;
    int   cfg_writes;
    int   settings_used;
    int   range_errors;
    int   big_endian_beats;
    int   quiet_cycles;

    can_signal_extract_scale_top i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Expected reading for one payload under the current register settings.
    // Big-endian order: nibble-swap every byte, pack byte 0 at the top, shift by the
    // position-derived amount, then nibble-swap the low 16 bits back.
    function automatic reading_t predict_reading(input logic [PAYLOAD_W-1:0] payload);
        logic [63:0] packed_be;
        logic [63:0] picked;
        logic [63:0] kept;
        logic [31:0] span;
        logic [31:0] num;
        int          shamt;
        reading_t    r;
        if (live_cfg.big_endian)
        begin
            for (int i = 0; i < 8; i++)
                packed_be[63-8*i -: 8] = {payload[8*i +: 4], payload[8*i+4 +: 4]};
            shamt = (7 - int'(live_cfg.first_bit[5:3])) * 8 + int'(live_cfg.first_bit[2:0]);
            packed_be = packed_be >> shamt;
            picked = {48'd0, packed_be[11:8], packed_be[15:12], packed_be[3:0], packed_be[7:4]};
        end
        else
            picked = payload >> live_cfg.first_bit;
        // A length of 64 or more keeps everything
        kept = picked & ((live_cfg.length >= 7'd64) ? {64{1'b1}}
                                                    : (64'd1 << live_cfg.length) - 64'd1);
        r.value = kept[VALUE_W-1:0];
        // Span, numerator and product all wrap at 32 bits
        span = 32'(live_cfg.scale_max) - 32'(live_cfg.scale_min);
        r.err = (span == 32'd0);
        r.code = '0;
        if (!r.err)
        begin
            num = (32'(r.value) - 32'(live_cfg.scale_min)) * 32'(DAC_FULL_SCALE);
            num = num / span;
            r.code = num[CODE_W-1:0];
        end
        return r;
    endfunction

    // Mostly back-to-back, sometimes a short gap, now and then a long gap
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic scaler_cfg_t draw_setting();
        scaler_cfg_t c;
        c.big_endian = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
            0:       c.first_bit = '0;
            1:       c.first_bit = '1;
            default: c.first_bit = SHIFT_W'($urandom_range(0, 63));
        endcase
        case ($urandom_range(0, 5))
            0:       c.length = 7'd0;
            1:       c.length = 7'd16;
            2:       c.length = 7'd64;
            3:       c.length = 7'd127;
            4:       c.length = LEN_W'($urandom_range(1, 16));
            default: c.length = LEN_W'($urandom_range(0, 127));
        endcase
        case ($urandom_range(0, 5))
            0:
            begin
                // equal bounds: range error on every beat
                c.scale_min = VALUE_W'($urandom);
                c.scale_max = c.scale_min;
            end
            1:
            begin
                c.scale_min = '0;
                c.scale_max = '1;
            end
            2:
            begin
                // inverted bounds: wrapped divisor
                c.scale_min = '1;
                c.scale_max = '0;
            end
            3:
            begin
                c.scale_min = VALUE_W'($urandom);
                c.scale_max = c.scale_min + VALUE_W'($urandom_range(1, 300));
            end
            default:
            begin
                c.scale_min = VALUE_W'($urandom);
                c.scale_max = VALUE_W'($urandom);
            end
        endcase
        return c;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_CAP)
            $display("%0d ns: result %0d: %s", $time, readings_checked, what);
    endtask

    // Compare one result beat against the oldest expected reading
    task automatic check_reading(input logic [OUT_TDATA_W-1:0] beat, input logic flag);
        reading_t got;
        reading_t want;
        got.value = beat[15:0];
        got.code  = beat[31:16];
        got.err   = flag;
        if (pending_readings.size() == 0)
            report_mismatch($sformatf("result beat %h with nothing outstanding", beat));
        else
        begin
            want = pending_readings.pop_front();
            if (got.value !== want.value)
                report_mismatch($sformatf("signal_value %h, expected %h", got.value, want.value));
            if (got.code !== want.code)
                report_mismatch($sformatf("dac_code %h, expected %h", got.code, want.code));
            if (got.err !== want.err)
                report_mismatch($sformatf("range_error %b, expected %b", got.err, want.err));
            readings_checked++;
        end
    endtask

    // One write beat on the config channel; call at a rising edge, leaves cfg_valid high
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        case (idx)
            CFG_BIG_ENDIAN: live_cfg.big_endian = data[0];
            CFG_FIRST_BIT:  live_cfg.first_bit  = data[SHIFT_W-1:0];
            CFG_LENGTH:     live_cfg.length     = data[LEN_W-1:0];
            CFG_SCALE_MIN:  live_cfg.scale_min  = data;
            CFG_SCALE_MAX:  live_cfg.scale_max  = data;
            default: ;  // unused index, dropped by the block
        endcase
        cfg_writes++;
    endtask

    // Drain the pipeline, then write all five registers. Unused upper data bits carry
    // noise, and half the time an unused index gets a write as well.
    task automatic program_scaler(input scaler_cfg_t c);
        s_tvalid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        write_reg(CFG_BIG_ENDIAN, {15'($urandom), c.big_endian});
        write_reg(CFG_FIRST_BIT, {10'($urandom), c.first_bit});
        write_reg(CFG_LENGTH, {9'($urandom), c.length});
        write_reg(CFG_SCALE_MIN, c.scale_min);
        write_reg(CFG_SCALE_MAX, c.scale_max);
        if ($urandom_range(0, 1) == 1)
            write_reg(CFG_SCALE_MAX + CFG_IDX_W'($urandom_range(1, 3)), CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Offer one payload beat after an optional gap; s_tvalid stays high afterwards so
    // the next beat can follow without a bubble. Record the expectation on accept.
    task automatic send_beat(input logic [PAYLOAD_W-1:0] payload, input int gap,
                             input reading_t want);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= payload;
        @(negedge clk);
        while (!s_tready)
            @(negedge clk);
        @(posedge clk);
        pending_readings.push_back(want);
        beats_sent++;
        if (want.err)
            range_errors++;
        if (live_cfg.big_endian)
            big_endian_beats++;
    endtask

    // Handshakes are sampled at the falling edge, where every input driven at the
    // rising edge and every registered output has settled. The same sample feeds
    // the result checker and the watchdog.
    always @(negedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            check_reading(m_tdata, m_tuser);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no beat moved for %0d cycles", quiet_cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Result sink. Alternate stretches of always-ready with stretches of random
    // stalls; on request hold m_tready low so the pipeline backs up into s_tready.
    initial
    begin
        int   stall_left;
        int   stretch_left;
        logic eager;
        stall_left   = 0;
        stretch_left = 0;
        eager        = 1'b0;
        m_tready     = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_sink)
            begin
                hold_sink = 1'b0;
                m_tready <= 1'b0;
                repeat (SINK_HOLD) @(posedge clk);
            end
            if (stretch_left == 0)
            begin
                eager        = ($urandom_range(0, 2) == 0);
                stretch_left = $urandom_range(40, 300);
            end
            stretch_left--;
            if (eager || stall_left == 0)
            begin
                m_tready <= 1'b1;
                if (!eager && $urandom_range(0, 2) == 0)
                    stall_left = pick_gap();
            end
            else
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
        end
    end

    // Stimulus
    initial
    begin
        int                   phase;
        int                   phase_len;
        logic                 burst;
        logic [PAYLOAD_W-1:0] payload;
        reading_t             want;

        clk       = 1'b0;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        hold_sink = 1'b0;
        mismatch_count   = 0;
        beats_sent       = 0;
        readings_checked = 0;
        random_beats     = 0;
        cfg_writes       = 0;
        settings_used    = 1;
        range_errors     = 0;
        big_endian_beats = 0;
        quiet_cycles     = 0;
        live_cfg = '{1'b0, '0, RST_LENGTH, RST_SCALE_MIN, RST_SCALE_MAX};

        // Rows run in order; a row whose settings differ from the current ones
        // drains the block and reprograms it first.
        directed_rows = '{
            // reset settings: all-zero and all-one payloads, then a mixed pattern
            '{'{1'b0, 6'd0, 7'd16, 16'd0, 16'hFFFF}, 64'h0, 1'b1,
              '{1'b0, 16'h0000, 16'h0000}},
            '{'{1'b0, 6'd0, 7'd16, 16'd0, 16'hFFFF}, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
              '{1'b0, 16'h0FFF, 16'hFFFF}},
            '{'{1'b0, 6'd0, 7'd16, 16'd0, 16'hFFFF}, 64'h0123_4567_89AB_CDEF, 1'b0, '0},
            // top start bit with a full-width mask: only payload bit 63 survives
            '{'{1'b0, 6'd63, 7'd64, 16'd0, 16'hFFFF}, 64'h8000_0000_0000_0000, 1'b1,
              '{1'b0, 16'h0000, 16'h0001}},
            '{'{1'b0, 6'd63, 7'd64, 16'd0, 16'hFFFF}, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1,
              '{1'b0, 16'h0000, 16'h0000}},
            // empty mask, full mask, oversized length field
            '{'{1'b0, 6'd0, 7'd0, 16'd0, 16'hFFFF}, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
              '{1'b0, 16'h0000, 16'h0000}},
            '{'{1'b0, 6'd0, 7'd64, 16'd0, 16'hFFFF}, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
              '{1'b0, 16'h0FFF, 16'hFFFF}},
            '{'{1'b0, 6'd8, 7'd127, 16'd0, 16'hFFFF}, 64'hA5C3_1E7F_0B96_D248, 1'b0, '0},
            // equal bounds: error flag, zero code, value still produced
            '{'{1'b0, 6'd0, 7'd16, 16'd1234, 16'd1234}, 64'h0000_0000_0000_FFFF, 1'b1,
              '{1'b1, 16'h0000, 16'hFFFF}},
            '{'{1'b0, 6'd0, 7'd16, 16'd0, 16'd0}, 64'h0000_0000_0000_5A5A, 1'b1,
              '{1'b1, 16'h0000, 16'h5A5A}},
            '{'{1'b0, 6'd0, 7'd16, 16'hFFFF, 16'hFFFF}, 64'h0, 1'b1,
              '{1'b1, 16'h0000, 16'h0000}},
            // max below min: wrapped divisor, wrapped numerator
            '{'{1'b0, 6'd0, 7'd16, 16'hFFFF, 16'd0}, 64'h0, 1'b0, '0},
            '{'{1'b0, 6'd0, 7'd16, 16'hFFFF, 16'd0}, 64'h0000_0000_0000_FFFF, 1'b1,
              '{1'b0, 16'h0000, 16'hFFFF}},
            // value below and inside a narrow range
            '{'{1'b0, 6'd0, 7'd16, 16'd1000, 16'd2000}, 64'd5, 1'b0, '0},
            '{'{1'b0, 6'd0, 7'd16, 16'd1000, 16'd2000}, 64'd1500, 1'b0, '0},
            // unit span: the quotient overflows 16 bits
            '{'{1'b0, 6'd0, 7'd16, 16'd0, 16'd1}, 64'h0000_0000_0000_FFFF, 1'b0, '0},
            '{'{1'b0, 6'd0, 7'd16, 16'd0, 16'd1}, 64'h1, 1'b1,
              '{1'b0, 16'h0FFF, 16'h0001}},
            // big-endian order across start bits and lengths
            '{'{1'b1, 6'd0, 7'd16, 16'd0, 16'hFFFF}, 64'h0123_4567_89AB_CDEF, 1'b0, '0},
            '{'{1'b1, 6'd7, 7'd16, 16'd0, 16'hFFFF}, 64'h0123_4567_89AB_CDEF, 1'b0, '0},
            '{'{1'b1, 6'd63, 7'd64, 16'd0, 16'hFFFF}, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
            '{'{1'b1, 6'd56, 7'd16, 16'd0, 16'hFFFF}, 64'hFEDC_BA98_7654_3210, 1'b0, '0},
            '{'{1'b1, 6'd12, 7'd0, 16'd0, 16'hFFFF}, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
              '{1'b0, 16'h0000, 16'h0000}},
            '{'{1'b1, 6'd3, 7'd127, 16'd0, 16'hFFFF}, 64'h3C96_E1A5_7F08_D24B, 1'b0, '0},
            '{'{1'b1, 6'd0, 7'd16, 16'd7, 16'd7}, 64'hFFFF_0000_FFFF_0000, 1'b0, '0}
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A write to an unused index must leave the reset settings alone
        write_reg(CFG_LAST_UNUSED, 16'hFFFF);
        cfg_valid <= 1'b0;

        foreach (directed_rows[k])
        begin
            if (directed_rows[k].cfg != live_cfg)
                program_scaler(directed_rows[k].cfg);
            want = directed_rows[k].typed ? directed_rows[k].want
                                          : predict_reading(directed_rows[k].payload);
            send_beat(directed_rows[k].payload, pick_gap(), want);
        end

        // Random phases: new settings, then a run of payloads. Phase 1 streams
        // back to back into a long sink hold; phase 3 pauses halfway until the
        // pipeline is empty.
        phase = 0;
        while (random_beats < RANDOM_BEATS)
        begin
            program_scaler(draw_setting());
            phase_len = (phase == 1) ? 80 : $urandom_range(30, 70);
            burst = (phase == 1) || ($urandom_range(0, 3) == 0);
            if (phase == 1)
                hold_sink = 1'b1;
            for (int n = 0; n < phase_len; n++)
            begin
                if (phase == 3 && n == phase_len / 2)
                begin
                    s_tvalid <= 1'b0;
                    while (pending_readings.size() != 0)
                        @(posedge clk);
                end
                case ($urandom_range(0, 15))
                    0:       payload = '0;
                    1:       payload = '1;
                    default: payload = {$urandom, $urandom};
                endcase
                send_beat(payload, burst ? 0 : pick_gap(), predict_reading(payload));
                random_beats++;
            end
            phase++;
        end

        // Drop valid, wait for the last result, then watch for strays
        s_tvalid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 5) @(posedge clk);

        $display("coverage: %0d payload beats (%0d from the directed table), %0d results checked",
                 beats_sent, N_DIRECTED, readings_checked);
        $display("coverage: %0d register settings, %0d config writes, %0d range errors,",
                 settings_used, cfg_writes, range_errors);
        $display("coverage: %0d big-endian beats", big_endian_beats);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

[sim.f]
sv/cse_pkg.sv
sv/cse_front.sv
sv/cse_div_cell.sv
sv/can_signal_extract_scale_top.sv
sim/testbench.sv
